/* hdl/tcw_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int ACTION_W = 2;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int INDEX_W = 11;
  localparam int KIND_W = 2;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;

  localparam int TAB_STOP = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W = 4;

  localparam logic [WORD_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ACTION_W-1:0] ACT_PUT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SERIAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_CR,
    ST_LF,
    ST_NEXT,
    ST_SCR_RD,
    ST_SCR_MV,
    ST_SCR_FILL,
    ST_CLEAR,
    ST_CLR_DONE,
    ST_RD,
    ST_RD_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INIT_FILL,
    OP_CLEAR_FILL,
    OP_CLEAR_DONE,
    OP_PUT,
    OP_CR,
    OP_LF,
    OP_SCROLL_READ,
    OP_SCROLL_MOVE,
    OP_SCROLL_FILL,
    OP_READ_ISSUE,
    OP_READ_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_end;
    logic shift_end;
    logic scroll_pending;
    logic more;
  } dp_status_t;

endpackage

/* hdl/tcw_ctrl.sv */
// Controller state machine that sequences transactions, sweeps and result strobes.
module tcw_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tcw_pkg::ACTION_W-1:0]   action,
  input  logic [tcw_pkg::BYTE_W-1:0]     character,
  input  tcw_pkg::dp_status_t            status,
  output tcw_pkg::dp_cmd_t               cmd,
  output logic                           busy
);
  import tcw_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_PUT:   state_next = (character == CHAR_NEWLINE) ? ST_CR : ST_PUT;
            ACT_CLEAR: state_next = ST_CLEAR;
            ACT_READ:  state_next = ST_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUT:  state_next = ST_NEXT;
      ST_CR:   state_next = ST_LF;
      ST_LF:   state_next = ST_NEXT;
      ST_NEXT: begin
        if (status.scroll_pending) state_next = ST_SCR_RD;
        else if (status.more) state_next = ST_PUT;
        else state_next = ST_IDLE;
      end
      ST_SCR_RD: state_next = ST_SCR_MV;
      ST_SCR_MV: state_next = status.shift_end ? ST_SCR_FILL : ST_SCR_RD;
      ST_SCR_FILL: begin
        if (status.sweep_end) state_next = ST_NEXT;
      end
      ST_CLEAR: begin
        if (status.sweep_end) state_next = ST_CLR_DONE;
      end
      ST_CLR_DONE: state_next = ST_IDLE;
      ST_RD:       state_next = ST_RD_DONE;
      ST_RD_DONE:  state_next = ST_IDLE;
      default:     state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    busy = 1'b1;
    case (state)
      ST_INIT: cmd.op = OP_INIT_FILL;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = OP_LATCH;
      end
      ST_PUT:      cmd.op = OP_PUT;
      ST_CR:       cmd.op = OP_CR;
      ST_LF:       cmd.op = OP_LF;
      ST_NEXT:     cmd.op = OP_NONE;
      ST_SCR_RD:   cmd.op = OP_SCROLL_READ;
      ST_SCR_MV:   cmd.op = OP_SCROLL_MOVE;
      ST_SCR_FILL: cmd.op = OP_SCROLL_FILL;
      ST_CLEAR:    cmd.op = OP_CLEAR_FILL;
      ST_CLR_DONE: cmd.op = OP_CLEAR_DONE;
      ST_RD:       cmd.op = OP_READ_ISSUE;
      ST_RD_DONE:  cmd.op = OP_READ_DONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

/* hdl/tcw_datapath.sv */
// Datapath: screen store, cursor, sweep address, latched transaction and result registers.
module tcw_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::dp_cmd_t              cmd,
  input  logic [tcw_pkg::BYTE_W-1:0]    character,
  input  logic [tcw_pkg::BYTE_W-1:0]    color,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  output tcw_pkg::dp_status_t           status,
  output logic                          strobe,
  output logic [tcw_pkg::KIND_W-1:0]    kind,
  output logic [tcw_pkg::BYTE_W-1:0]    serial_byte,
  output logic [tcw_pkg::WORD_W-1:0]    cell_word,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic                          last
);
  import tcw_pkg::*;

  logic [WORD_W-1:0] screen_mem [CELLS];
  logic [WORD_W-1:0] rdata;

  logic [ADDR_W-1:0] addr;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              scroll_pending;
  logic              more;
  logic [CNT_W-1:0]  count;

  logic [BYTE_W-1:0]  put_char;
  logic [BYTE_W-1:0]  put_color;
  logic [INDEX_W-1:0] rd_index;
  logic               tab;
  logic               in_range;

  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_adv;
  logic               adv_scroll;
  logic               pend_set;
  logic [CNT_W-1:0]   count_inc;
  logic               more_next;
  logic               sweep_end;
  logic [ADDR_W-1:0]  addr_step;

  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [WORD_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;

  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [BYTE_W-1:0]  emit_byte;
  logic [WORD_W-1:0]  emit_word;
  logic               emit_last;

  assign sweep_end = (addr == ADDR_W'(CELLS - 1));
  assign addr_step = sweep_end ? '0 : addr + 1'b1;
  assign count_inc = count + 1'b1;

  assign status.sweep_end = sweep_end;
  assign status.shift_end = (addr == ADDR_W'(CELLS - COLUMNS - 1));
  assign status.scroll_pending = scroll_pending;
  assign status.more = more;

  always_comb begin
    if (int'(row) + 1 >= ROWS) begin
      row_adv = ROW_W'(ROWS - 1);
      adv_scroll = 1'b1;
    end else begin
      row_adv = row + 1'b1;
      adv_scroll = 1'b0;
    end
  end

  always_comb begin
    row_next = row;
    col_next = col;
    pend_set = 1'b0;
    case (cmd.op)
      OP_PUT: begin
        if (int'(col) + 1 >= COLUMNS) begin
          col_next = '0;
          row_next = row_adv;
          pend_set = adv_scroll;
        end else begin
          col_next = col + 1'b1;
        end
      end
      OP_CR: begin
        col_next = '0;
        row_next = row_adv;
        pend_set = adv_scroll;
      end
      OP_CLEAR_DONE: begin
        col_next = '0;
        row_next = '0;
      end
      default: begin
        row_next = row;
        col_next = col;
      end
    endcase
  end

  assign more_next = tab && ((col_next & COL_W'(TAB_STOP - 1)) != '0)
                     && (count_inc < CNT_W'(MAX_RESULTS));

  always_comb begin
    mem_we = 1'b0;
    waddr = addr;
    wdata = BLANK_CELL;
    raddr = ADDR_W'(rd_index);
    emit = 1'b0;
    emit_kind = KIND_SERIAL;
    emit_byte = '0;
    emit_word = '0;
    emit_last = 1'b1;
    case (cmd.op)
      OP_INIT_FILL: begin
        mem_we = 1'b1;
      end
      OP_CLEAR_FILL: begin
        mem_we = 1'b1;
        wdata = {put_color, CHAR_SPACE};
      end
      OP_CLEAR_DONE: begin
        emit = 1'b1;
        emit_kind = KIND_CLEAR;
        emit_word = {put_color, CHAR_SPACE};
      end
      OP_PUT: begin
        mem_we = 1'b1;
        waddr = ADDR_W'(int'(row) * COLUMNS + int'(col));
        wdata = {put_color, put_char};
        emit = 1'b1;
        emit_byte = put_char;
        emit_word = {put_color, put_char};
        emit_last = !more_next;
      end
      OP_CR: begin
        emit = 1'b1;
        emit_byte = CHAR_CR;
        emit_last = 1'b0;
      end
      OP_LF: begin
        emit = 1'b1;
        emit_byte = CHAR_NEWLINE;
      end
      OP_SCROLL_READ: begin
        raddr = ADDR_W'(int'(addr) + COLUMNS);
      end
      OP_SCROLL_MOVE: begin
        mem_we = 1'b1;
        wdata = rdata;
      end
      OP_SCROLL_FILL: begin
        mem_we = 1'b1;
      end
      OP_READ_DONE: begin
        emit = 1'b1;
        emit_kind = KIND_READ;
        emit_word = in_range ? rdata : '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen_mem[waddr] <= wdata;
    rdata <= screen_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      row <= '0;
      col <= '0;
      scroll_pending <= 1'b0;
      more <= 1'b0;
      count <= '0;
      strobe <= 1'b0;
    end else begin
      row <= row_next;
      col <= col_next;
      strobe <= emit;
      if (pend_set) scroll_pending <= 1'b1;
      case (cmd.op)
        OP_LATCH: begin
          more <= 1'b0;
          count <= '0;
        end
        OP_PUT: begin
          more <= more_next;
          count <= count_inc;
        end
        OP_INIT_FILL, OP_CLEAR_FILL, OP_SCROLL_MOVE: begin
          addr <= addr_step;
        end
        OP_SCROLL_FILL: begin
          addr <= addr_step;
          if (sweep_end) scroll_pending <= 1'b0;
        end
        default: begin
          addr <= addr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      tab <= (character == CHAR_TAB);
      put_char <= (character == CHAR_TAB) ? CHAR_SPACE : character;
      put_color <= color;
      rd_index <= cell_index;
      in_range <= (int'(cell_index) < CELLS);
    end
    if (emit) begin
      kind <= emit_kind;
      serial_byte <= emit_byte;
      cell_word <= emit_word;
      cursor_row <= row_next;
      cursor_column <= col_next;
      last <= emit_last;
    end
  end

endmodule

/* hdl/text_console_writer.sv */
// Top level of the text console writer: controller and datapath.
// A scroll runs after the last strobe of a put, as a sweep of the screen store that moves
// every row below the top up by one and fills the bottom row with 0x0720.
// One transaction at a time: start is taken only while busy is low; the receiver cannot stall.
// Reset: synchronous rst homes the cursor and runs a clearing pass over all ROWS*COLUMNS
// cells (2000) that fills the store with 0x0720 while busy stays high.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcw_pkg::ACTION_W-1:0]  action,
  input  logic [tcw_pkg::BYTE_W-1:0]    character,
  input  logic [tcw_pkg::BYTE_W-1:0]    color,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  output logic                          strobe,
  output logic [tcw_pkg::KIND_W-1:0]    kind,
  output logic [tcw_pkg::BYTE_W-1:0]    serial_byte,
  output logic [tcw_pkg::WORD_W-1:0]    cell_word,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic                          last
);
  import tcw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .character (character),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  tcw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .character     (character),
    .color         (color),
    .cell_index    (cell_index),
    .status        (status),
    .strobe        (strobe),
    .kind          (kind),
    .serial_byte   (serial_byte),
    .cell_word     (cell_word),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .last          (last)
  );

endmodule

/* verif/text_console_checker.sv */
// Checker for the text console writer: tracks screen and cursor, predicts and compares results.
module text_console_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [tcw_pkg::ACTION_W-1:0] action,
  input  logic [tcw_pkg::BYTE_W-1:0]   character,
  input  logic [tcw_pkg::BYTE_W-1:0]   color,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
  input  logic                         strobe,
  input  logic [tcw_pkg::KIND_W-1:0]   kind,
  input  logic [tcw_pkg::BYTE_W-1:0]   serial_byte,
  input  logic [tcw_pkg::WORD_W-1:0]   cell_word,
  input  logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  input  logic [tcw_pkg::COL_W-1:0]    cursor_column,
  input  logic                         last,
  output int                           mismatch_count,
  output int                           expected_left
);
  import tcw_pkg::*;

  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] serial_byte;
    logic [WORD_W-1:0] cell_word;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              last;
  } console_result_t;

  logic [WORD_W-1:0] screen [CELLS];
  int                row_pos = 0;
  int                col_pos = 0;
  console_result_t   item_results [MAX_RESULTS];
  int                item_count = 0;
  console_result_t   pending_results [$];
  console_result_t   oldest;
  int                result_seq = 0;

  initial begin
    mismatch_count = 0;
    expected_left = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $realtime, result_seq,
               what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void stage_result(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                                       input logic [WORD_W-1:0] w);
    item_results[item_count] = '{kind: k, serial_byte: b, cell_word: w,
                                 cursor_row: ROW_W'(row_pos), cursor_column: COL_W'(col_pos),
                                 last: 1'b0};
    item_count++;
  endfunction

  function automatic void scroll_screen();
    if (row_pos < ROWS) begin
      return;
    end
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen[i] = screen[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen[i] = BLANK_CELL;
    end
    row_pos = ROWS - 1;
  endfunction

  function automatic void print_cell(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] clr);
    logic [WORD_W-1:0] word;
    word = {clr, ch};
    screen[row_pos * COLUMNS + col_pos] = word;
    col_pos++;
    if (col_pos >= COLUMNS) begin
      col_pos = 0;
      row_pos++;
      scroll_screen();
    end
    stage_result(KIND_SERIAL, ch, word);
  endfunction

  function automatic void apply_console_item(input logic [ACTION_W-1:0] act,
                                             input logic [BYTE_W-1:0] ch,
                                             input logic [BYTE_W-1:0] clr,
                                             input logic [INDEX_W-1:0] idx);
    item_count = 0;
    case (act)
      ACT_PUT: begin
        if (ch == CHAR_NEWLINE) begin
          col_pos = 0;
          row_pos++;
          scroll_screen();
          stage_result(KIND_SERIAL, CHAR_CR, '0);
          stage_result(KIND_SERIAL, CHAR_NEWLINE, '0);
        end else if (ch == CHAR_TAB) begin
          print_cell(CHAR_SPACE, clr);
          while ((col_pos % TAB_STOP) != 0 && item_count < MAX_RESULTS) begin
            print_cell(CHAR_SPACE, clr);
          end
        end else begin
          print_cell(ch, clr);
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen[i] = {clr, CHAR_SPACE};
        end
        row_pos = 0;
        col_pos = 0;
        stage_result(KIND_CLEAR, '0, {clr, CHAR_SPACE});
      end
      ACT_READ: begin
        stage_result(KIND_READ, '0, (int'(idx) < CELLS) ? screen[idx] : '0);
      end
      default: begin
      end
    endcase
    if (item_count > 0) begin
      item_results[item_count - 1].last = 1'b1;
    end
    for (int i = 0; i < item_count; i++) begin
      pending_results.push_back(item_results[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        screen[i] = BLANK_CELL;
      end
      row_pos = 0;
      col_pos = 0;
      pending_results.delete();
    end else begin
      if (strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected strobe, kind", 32'(kind), '0);
        end else begin
          oldest = pending_results.pop_front();
          compare_field("kind", 32'(kind), 32'(oldest.kind));
          compare_field("serial_byte", 32'(serial_byte), 32'(oldest.serial_byte));
          compare_field("cell_word", 32'(cell_word), 32'(oldest.cell_word));
          compare_field("cursor_row", 32'(cursor_row), 32'(oldest.cursor_row));
          compare_field("cursor_column", 32'(cursor_column), 32'(oldest.cursor_column));
          compare_field("last", 32'(last), 32'(oldest.last));
        end
        result_seq++;
      end
      if (start && !busy) begin
        apply_console_item(action, character, color, cell_index);
      end
    end
    expected_left <= pending_results.size();
  end

endmodule

/* verif/tb_text_console_writer.sv */
// Testbench top for the text console writer: clock, reset, stimulus, watchdog and verdict.
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 210;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 4000;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [ACTION_W-1:0] action = ACT_PUT;
  logic [BYTE_W-1:0]   character = '0;
  logic [BYTE_W-1:0]   color = '0;
  logic [INDEX_W-1:0]  cell_index = '0;
  logic                busy;
  logic                strobe;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   serial_byte;
  logic [WORD_W-1:0]   cell_word;
  logic [ROW_W-1:0]    cursor_row;
  logic [COL_W-1:0]    cursor_column;
  logic                last;

  int mismatch_count;
  int expected_left;
  int idle_cycles = 0;
  int sent_items = 0;
  int burst_left = 0;

  text_console_writer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .character     (character),
    .color         (color),
    .cell_index    (cell_index),
    .strobe        (strobe),
    .kind          (kind),
    .serial_byte   (serial_byte),
    .cell_word     (cell_word),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .last          (last)
  );

  text_console_checker console_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .character      (character),
    .color          (color),
    .cell_index     (cell_index),
    .strobe         (strobe),
    .kind           (kind),
    .serial_byte    (serial_byte),
    .cell_word      (cell_word),
    .cursor_row     (cursor_row),
    .cursor_column  (cursor_column),
    .last           (last),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_writer verification failed");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] random_byte();
    return BYTE_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [INDEX_W-1:0] pick_cell();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 40) begin
      return INDEX_W'($urandom_range(2047, 0));
    end else if (roll < 70) begin
      return INDEX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS));
    end
    return INDEX_W'($urandom_range(2 * COLUMNS - 1, 0));
  endfunction

  function automatic logic [ACTION_W-1:0] noise_action();
    case ($urandom_range(2, 0))
      0: return ACT_PUT;
      1: return ACT_READ;
      default: return ACT_UNUSED;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      burst_left = $urandom_range(30, 10);
      return 0;
    end else if (roll < 50) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] ch,
                           input logic [BYTE_W-1:0] clr, input logic [INDEX_W-1:0] idx);
    int gap;
    start <= 1'b1;
    action <= act;
    character <= ch;
    color <= clr;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    if (act != ACT_UNUSED) begin
      sent_items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_text(input int count, input logic [BYTE_W-1:0] clr);
    repeat (count) begin
      if ($urandom_range(3, 0) == 0) begin
        send_item(ACT_PUT, CHAR_TAB, clr, pick_cell());
      end else begin
        send_item(ACT_PUT, random_byte(), clr, pick_cell());
      end
    end
  endtask

  task automatic directed_items();
    send_item(ACT_READ, 8'h00, 8'h00, '0);
    send_item(ACT_READ, 8'hFF, 8'hFF, INDEX_W'(CELLS - 1));
    send_item(ACT_READ, 8'h00, 8'h00, INDEX_W'(CELLS));
    send_item(ACT_READ, 8'hFF, 8'hFF, '1);
    send_item(ACT_PUT, 8'h00, 8'h00, '0);
    send_item(ACT_PUT, 8'hFF, 8'hFF, '1);
    send_item(ACT_PUT, 8'h41, 8'h1E, '0);
    send_item(ACT_READ, 8'h00, 8'h00, INDEX_W'(0));
    send_item(ACT_READ, 8'h00, 8'h00, INDEX_W'(1));
    send_item(ACT_PUT, CHAR_TAB, 8'h4F, '0);
    send_item(ACT_PUT, CHAR_TAB, 8'h00, '0);
    send_item(ACT_PUT, CHAR_NEWLINE, 8'hA5, '0);
    send_item(ACT_PUT, CHAR_CR, 8'h07, '0);
    send_item(ACT_READ, 8'h00, 8'h00, INDEX_W'(COLUMNS));
    send_item(ACT_UNUSED, CHAR_NEWLINE, 8'hFF, '1);
    send_item(ACT_CLEAR, 8'h00, 8'hFF, '0);
    send_item(ACT_READ, 8'h00, 8'h00, INDEX_W'(CELLS - 1));
    send_item(ACT_CLEAR, 8'hFF, 8'h00, '1);
    send_item(ACT_READ, 8'h00, 8'h00, '0);
    send_item(ACT_PUT, CHAR_SPACE, 8'h5A, '0);
    send_item(ACT_PUT, CHAR_NEWLINE, 8'h00, '0);
  endtask

  task automatic random_items();
    int roll;
    logic [BYTE_W-1:0] clr;
    while (sent_items < ITEM_TARGET) begin
      roll = $urandom_range(99, 0);
      clr = random_byte();
      if (roll < 45) begin
        put_text($urandom_range(8, 1), clr);
        send_item(ACT_PUT, CHAR_NEWLINE, clr, pick_cell());
      end else if (roll < 60) begin
        put_text($urandom_range(60, 10), clr);
      end else if (roll < 72) begin
        repeat ($urandom_range(4, 1)) send_item(ACT_READ, random_byte(), clr, pick_cell());
      end else if (roll < 82) begin
        repeat ($urandom_range(10, 2)) send_item(ACT_PUT, CHAR_NEWLINE, random_byte(), pick_cell());
      end else if (roll < 96) begin
        repeat ($urandom_range(3, 1)) begin
          send_item(noise_action(), random_byte(), random_byte(),
                    INDEX_W'($urandom_range(2047, 0)));
        end
      end else begin
        send_item(ACT_CLEAR, random_byte(), clr, pick_cell());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    random_items();
    start <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

endmodule
